// ----- sv/rrts_pkg.sv -----
// Shared types and constants of the round-robin task scheduler.
package rrts_pkg;

    localparam int TASK_SLOTS_DEF = 16;

    localparam int REQ_W      = 2;
    localparam int ID_W       = 4;
    localparam int FTD_W      = 13;
    localparam int RES_TASK_W = 4;
    localparam int SEL_W      = 16;
    localparam int STATUS_W   = 2;

    localparam logic [FTD_W-1:0] FTD_RESET = 13'd3;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC = 2'd0,
        REQ_RUN   = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_SLEEP = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        SLOT_FREE  = 2'd0,
        SLOT_ALLOC = 2'd1,
        SLOT_RUN   = 2'd2
    } slot_state_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    typedef struct packed {
        status_t status;
        logic    switch_now;
        logic    has_slot;
    } res_flags_t;

endpackage

// ----- sv/rrts_slot_mem.sv -----
// Slot state memory with per-slot valid bits standing in for the reset contents.
module rrts_slot_mem
    import rrts_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF,
    localparam int SW = $clog2(TASK_SLOTS)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [SW-1:0] rd_addr,
    output slot_state_t   rd_data,
    input  logic          wr_en,
    input  logic [SW-1:0] wr_addr,
    input  slot_state_t   wr_data
);

    slot_state_t             mem [TASK_SLOTS];
    slot_state_t             rd_mem_reg;
    logic [TASK_SLOTS-1:0]   valid_reg;
    logic                    rd_valid_reg;
    logic                    rd_zero_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_mem_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_zero_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
            rd_zero_reg  <= (rd_addr == '0);
        end
    end

    // unwritten slots read as their reset state: slot zero running, the rest free
    assign rd_data = rd_valid_reg ? rd_mem_reg : (rd_zero_reg ? SLOT_RUN : SLOT_FREE);

endmodule

// ----- sv/rrts_list_mem.sv -----
// Run list memory with per-entry valid bits; unwritten entries read as zero.
module rrts_list_mem
    import rrts_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF,
    localparam int SW = $clog2(TASK_SLOTS)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [SW-1:0] rd_addr,
    output logic [SW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [SW-1:0] wr_addr,
    input  logic [SW-1:0] wr_data
);

    logic [SW-1:0]         mem [TASK_SLOTS];
    logic [SW-1:0]         rd_mem_reg;
    logic [TASK_SLOTS-1:0] valid_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_mem_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_mem_reg : '0;

endmodule

// ----- sv/rrts_ctrl.sv -----
// Request sequencer: scans slots and the run list through one shared incrementer.
module rrts_ctrl
    import rrts_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF,
    localparam int SW = $clog2(TASK_SLOTS),
    localparam int CW = $clog2(TASK_SLOTS + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  req_t            in_req,
    input  logic [ID_W-1:0] in_id,
    output logic [SW-1:0]   slot_rd_addr,
    input  slot_state_t     slot_rd_data,
    output logic            slot_wr_en,
    output logic [SW-1:0]   slot_wr_addr,
    output slot_state_t     slot_wr_data,
    output logic [SW-1:0]   list_rd_addr,
    input  logic [SW-1:0]   list_rd_data,
    output logic            list_wr_en,
    output logic [SW-1:0]   list_wr_addr,
    output logic [SW-1:0]   list_wr_data,
    output logic            res_valid,
    input  logic            res_ready,
    output res_flags_t      res_flags,
    output logic [SW-1:0]   res_slot
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC,
        S_RUN_CHK,
        S_SLP_CHK,
        S_SLP_FIND,
        S_SLP_SHIFT,
        S_SLP_FIN,
        S_SWITCH,
        S_OUT
    } state_t;

    localparam logic [CW-1:0] SLOTS_C = CW'(TASK_SLOTS);

    state_t          state_reg,     state_next;
    logic [ID_W-1:0] id_reg,        id_next;
    logic            id_ok_reg,     id_ok_next;
    logic [CW-1:0]   count_reg,     count_next;
    logic [SW-1:0]   pos_reg,       pos_next;
    logic [SW-1:0]   scan_reg,      scan_next;
    logic [SW-1:0]   wptr_reg,      wptr_next;
    logic            was_cur_reg,   was_cur_next;
    res_flags_t      res_flags_reg, res_flags_next;
    logic [SW-1:0]   res_slot_reg,  res_slot_next;

    // shared incrementer, steered by the sequencer
    logic [SW-1:0]   step_a;
    logic [CW-1:0]   step_sum;
    logic [SW-1:0]   id_slot;
    logic [SW-1:0]   pos_fin;

    assign step_a   = (state_reg == S_IDLE) ? pos_reg : scan_reg;
    assign step_sum = CW'(step_a) + CW'(1);
    assign id_slot  = SW'(id_reg);
    assign pos_fin  = (was_cur_reg || (CW'(pos_reg) >= count_reg)) ? '0 : pos_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res_flags = res_flags_reg;
    assign res_slot  = res_slot_reg;

    always_comb
    begin
        state_next     = state_reg;
        id_next        = id_reg;
        id_ok_next     = id_ok_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        scan_next      = scan_reg;
        wptr_next      = wptr_reg;
        was_cur_next   = was_cur_reg;
        res_flags_next = res_flags_reg;
        res_slot_next  = res_slot_reg;
        slot_rd_addr   = id_slot;
        slot_wr_en     = 1'b0;
        slot_wr_addr   = id_slot;
        slot_wr_data   = SLOT_ALLOC;
        list_rd_addr   = pos_reg;
        list_wr_en     = 1'b0;
        list_wr_addr   = wptr_reg;
        list_wr_data   = list_rd_data;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    id_next    = in_id;
                    id_ok_next = (int'(in_id) < TASK_SLOTS);
                    case (in_req)
                        REQ_ALLOC:
                        begin
                            slot_rd_addr = '0;
                            scan_next    = '0;
                            state_next   = S_ALLOC;
                        end
                        REQ_RUN:
                        begin
                            slot_rd_addr = SW'(in_id);
                            state_next   = S_RUN_CHK;
                        end
                        REQ_TICK:
                        begin
                            if (count_reg >= CW'(2))
                            begin
                                // advance and wrap the current position
                                pos_next     = (step_sum >= count_reg) ? '0 : SW'(step_sum);
                                list_rd_addr = pos_next;
                                state_next   = S_SWITCH;
                            end
                            else
                            begin
                                res_flags_next = '{status: ST_OK, switch_now: 1'b0,
                                                   has_slot: 1'b0};
                                state_next     = S_OUT;
                            end
                        end
                        REQ_SLEEP:
                        begin
                            slot_rd_addr = SW'(in_id);
                            list_rd_addr = pos_reg;
                            state_next   = S_SLP_CHK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_ALLOC:
            begin
                if (slot_rd_data == SLOT_FREE)
                begin
                    slot_wr_en     = 1'b1;
                    slot_wr_addr   = scan_reg;
                    slot_wr_data   = SLOT_ALLOC;
                    res_flags_next = '{status: ST_OK, switch_now: 1'b0, has_slot: 1'b1};
                    res_slot_next  = scan_reg;
                    state_next     = S_OUT;
                end
                else if (step_sum == SLOTS_C)
                begin
                    res_flags_next = '{status: ST_FULL, switch_now: 1'b0, has_slot: 1'b0};
                    state_next     = S_OUT;
                end
                else
                begin
                    scan_next    = SW'(step_sum);
                    slot_rd_addr = SW'(step_sum);
                end
            end

            S_RUN_CHK:
            begin
                if (id_ok_reg && (slot_rd_data == SLOT_ALLOC) && (count_reg < SLOTS_C))
                begin
                    slot_wr_en     = 1'b1;
                    slot_wr_data   = SLOT_RUN;
                    list_wr_en     = 1'b1;
                    list_wr_addr   = SW'(count_reg);
                    list_wr_data   = id_slot;
                    count_next     = count_reg + CW'(1);
                    res_flags_next = '{status: ST_OK, switch_now: 1'b0, has_slot: 1'b0};
                end
                else
                begin
                    res_flags_next = '{status: ST_IGNORED, switch_now: 1'b0, has_slot: 1'b0};
                end
                state_next = S_OUT;
            end

            S_SLP_CHK:
            begin
                if (id_ok_reg && (slot_rd_data == SLOT_RUN) && (count_reg != '0))
                begin
                    was_cur_next = (CW'(pos_reg) < count_reg) && (list_rd_data == id_slot);
                    scan_next    = '0;
                    list_rd_addr = '0;
                    state_next   = S_SLP_FIND;
                end
                else
                begin
                    res_flags_next = '{status: ST_IGNORED, switch_now: 1'b0, has_slot: 1'b0};
                    state_next     = S_OUT;
                end
            end

            S_SLP_FIND:
            begin
                if (list_rd_data == id_slot)
                begin
                    slot_wr_en = 1'b1;
                    count_next = count_reg - CW'(1);
                    if (scan_reg < pos_reg)
                    begin
                        pos_next = pos_reg - SW'(1);
                    end
                    // close the gap only when entries follow the removed one
                    if (step_sum < count_reg)
                    begin
                        list_rd_addr = SW'(step_sum);
                        wptr_next    = scan_reg;
                        scan_next    = SW'(step_sum);
                        state_next   = S_SLP_SHIFT;
                    end
                    else
                    begin
                        state_next = S_SLP_FIN;
                    end
                end
                else if (step_sum >= count_reg)
                begin
                    // not on the list: drop the running mark only
                    slot_wr_en     = 1'b1;
                    res_flags_next = '{status: ST_IGNORED, switch_now: 1'b0, has_slot: 1'b0};
                    state_next     = S_OUT;
                end
                else
                begin
                    scan_next    = SW'(step_sum);
                    list_rd_addr = SW'(step_sum);
                end
            end

            S_SLP_SHIFT:
            begin
                list_wr_en   = 1'b1;
                list_wr_addr = wptr_reg;
                list_wr_data = list_rd_data;
                if (CW'(scan_reg) < count_reg)
                begin
                    list_rd_addr = SW'(step_sum);
                    wptr_next    = scan_reg;
                    scan_next    = SW'(step_sum);
                end
                else
                begin
                    state_next = S_SLP_FIN;
                end
            end

            S_SLP_FIN:
            begin
                pos_next = pos_fin;
                if (count_reg != '0)
                begin
                    list_rd_addr = pos_fin;
                    state_next   = S_SWITCH;
                end
                else
                begin
                    res_flags_next = '{status: ST_OK, switch_now: 1'b0, has_slot: 1'b0};
                    state_next     = S_OUT;
                end
            end

            S_SWITCH:
            begin
                res_flags_next = '{status: ST_OK, switch_now: 1'b1, has_slot: 1'b1};
                res_slot_next  = list_rd_data;
                state_next     = S_OUT;
            end

            S_OUT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            id_reg        <= '0;
            id_ok_reg     <= 1'b0;
            count_reg     <= CW'(1);
            pos_reg       <= '0;
            scan_reg      <= '0;
            wptr_reg      <= '0;
            was_cur_reg   <= 1'b0;
            res_flags_reg <= '{status: ST_OK, switch_now: 1'b0, has_slot: 1'b0};
            res_slot_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            id_reg        <= id_next;
            id_ok_reg     <= id_ok_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            scan_reg      <= scan_next;
            wptr_reg      <= wptr_next;
            was_cur_reg   <= was_cur_next;
            res_flags_reg <= res_flags_next;
            res_slot_reg  <= res_slot_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SLOTS_C)
        else $error("run count exceeds slot count");

    a_pos_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) && (count_reg != '0) |-> (CW'(pos_reg) < count_reg))
        else $error("current position outside run list");

    a_pos_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) && (count_reg == '0) |-> (pos_reg == '0))
        else $error("position not zero with empty run list");

    a_switch_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_flags.switch_now |-> res_flags.has_slot && (res_flags.status == ST_OK))
        else $error("switch result without target slot");
`endif

endmodule

// ----- sv/round_robin_task_scheduler.sv -----
// Top level of the round-robin task scheduler: ports, descriptor base register, result register.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tuser[1:0] req_type, tdata[3:0] task_id
//  m_*       out  m_tvalid/m_tready  tdata: status, switch_now, result_task, selector
//  cfg_*     in   cfg_wen            cfg_wdata first_task_descriptor
//
// Alloc reads one slot state per cycle while it scans; sleep searches the run list,
// then moves one entry per cycle through the run list memory port.
// One request at a time; s_tready is low until the result enters the output register.
// Reset leaves slot zero running and alone on the run list; there is no clearing pass.
// A stalled m_tready holds the result and blocks the sequencer.
module round_robin_task_scheduler
    import rrts_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [3:0] task_id, [7:4] zero
    input  logic [1:0]       s_tuser,   // [1:0] req_type
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,   // [1:0] status, [2] switch_now, [6:3] result_task,
                                        // [22:7] selector, [23] zero
    input  logic             cfg_wen,
    input  logic [FTD_W-1:0] cfg_wdata
);

    localparam int SW = $clog2(TASK_SLOTS);

    logic [FTD_W-1:0] ftd_reg;
    logic             m_tvalid_reg;
    logic [23:0]      m_tdata_reg;

    logic [SW-1:0]    slot_rd_addr;
    slot_state_t      slot_rd_data;
    logic             slot_wr_en;
    logic [SW-1:0]    slot_wr_addr;
    slot_state_t      slot_wr_data;
    logic [SW-1:0]    list_rd_addr;
    logic [SW-1:0]    list_rd_data;
    logic             list_wr_en;
    logic [SW-1:0]    list_wr_addr;
    logic [SW-1:0]    list_wr_data;
    logic             res_valid;
    logic             res_ready;
    res_flags_t       res_flags;
    logic [SW-1:0]    res_slot;

    logic [RES_TASK_W-1:0] out_task;
    logic [SEL_W-1:0]      out_sel;

    rrts_ctrl #(.TASK_SLOTS(TASK_SLOTS)) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_req       (req_t'(s_tuser[1:0])),
        .in_id        (s_tdata[ID_W-1:0]),
        .slot_rd_addr (slot_rd_addr),
        .slot_rd_data (slot_rd_data),
        .slot_wr_en   (slot_wr_en),
        .slot_wr_addr (slot_wr_addr),
        .slot_wr_data (slot_wr_data),
        .list_rd_addr (list_rd_addr),
        .list_rd_data (list_rd_data),
        .list_wr_en   (list_wr_en),
        .list_wr_addr (list_wr_addr),
        .list_wr_data (list_wr_data),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res_flags    (res_flags),
        .res_slot     (res_slot)
    );

    rrts_slot_mem #(.TASK_SLOTS(TASK_SLOTS)) u_slot_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd_data),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data)
    );

    rrts_list_mem #(.TASK_SLOTS(TASK_SLOTS)) u_list_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (list_rd_addr),
        .rd_data (list_rd_data),
        .wr_en   (list_wr_en),
        .wr_addr (list_wr_addr),
        .wr_data (list_wr_data)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    // selector is (descriptor base + slot) * 8; no slot gives zeros
    assign out_task = res_flags.has_slot ? RES_TASK_W'(res_slot) : '0;
    assign out_sel  = res_flags.has_slot ?
                      SEL_W'((SEL_W'(ftd_reg) + SEL_W'(res_slot)) << 3) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ftd_reg      <= FTD_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                ftd_reg <= cfg_wdata;
            end
            if (res_ready)
            begin
                m_tvalid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_tdata_reg <= {1'b0, out_sel, out_task, res_flags.switch_now, res_flags.status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- test/round_robin_task_scheduler_tb.sv -----
// Self-checking testbench of the round-robin task scheduler: directed table, then random requests.
module round_robin_task_scheduler_tb;
    import rrts_pkg::*;

    typedef struct packed {
        status_t     status;
        logic        switch_now;
        logic [3:0]  slot;
        logic [15:0] selector;
    } sched_result_t;

    typedef struct packed {
        req_t          req;
        logic [3:0]    id;
        logic [3:0]    reps;
        logic          typed;
        sched_result_t want;
    } stim_row_t;

    localparam sched_result_t RES_NONE    = '{ST_OK, 1'b0, 4'd0, 16'd0};
    localparam sched_result_t RES_IGNORED = '{ST_IGNORED, 1'b0, 4'd0, 16'd0};
    localparam sched_result_t RES_FULL    = '{ST_FULL, 1'b0, 4'd0, 16'd0};

    localparam int N_ROWS = 27;
    localparam stim_row_t DIRECTED [0:N_ROWS-1] = '{
        '{REQ_TICK,  4'd0,  4'd1,  1'b1, RES_NONE},
        '{REQ_SLEEP, 4'd5,  4'd1,  1'b1, RES_IGNORED},
        '{REQ_RUN,   4'd5,  4'd1,  1'b1, RES_IGNORED},
        '{REQ_ALLOC, 4'd0,  4'd1,  1'b1, '{ST_OK, 1'b0, 4'd1, 16'd32}},
        '{REQ_ALLOC, 4'd15, 4'd1,  1'b1, '{ST_OK, 1'b0, 4'd2, 16'd40}},
        '{REQ_RUN,   4'd1,  4'd1,  1'b1, RES_NONE},
        '{REQ_RUN,   4'd1,  4'd1,  1'b1, RES_IGNORED},
        '{REQ_TICK,  4'd0,  4'd1,  1'b1, '{ST_OK, 1'b1, 4'd1, 16'd32}},
        '{REQ_RUN,   4'd2,  4'd1,  1'b0, RES_NONE},
        '{REQ_TICK,  4'd0,  4'd1,  1'b0, RES_NONE},
        '{REQ_TICK,  4'd15, 4'd1,  1'b0, RES_NONE},
        '{REQ_SLEEP, 4'd2,  4'd1,  1'b0, RES_NONE},
        '{REQ_TICK,  4'd0,  4'd1,  1'b0, RES_NONE},
        '{REQ_SLEEP, 4'd1,  4'd1,  1'b0, RES_NONE},
        '{REQ_SLEEP, 4'd0,  4'd1,  1'b1, RES_NONE},
        '{REQ_TICK,  4'd0,  4'd1,  1'b1, RES_NONE},
        '{REQ_SLEEP, 4'd0,  4'd1,  1'b1, RES_IGNORED},
        '{REQ_ALLOC, 4'd0,  4'd13, 1'b0, RES_NONE},
        '{REQ_ALLOC, 4'd0,  4'd1,  1'b1, RES_FULL},
        '{REQ_RUN,   4'd0,  4'd1,  1'b0, RES_NONE},
        '{REQ_RUN,   4'd3,  4'd1,  1'b0, RES_NONE},
        '{REQ_RUN,   4'd15, 4'd1,  1'b0, RES_NONE},
        '{REQ_TICK,  4'd0,  4'd1,  1'b0, RES_NONE},
        '{REQ_TICK,  4'd0,  4'd1,  1'b0, RES_NONE},
        '{REQ_SLEEP, 4'd0,  4'd1,  1'b0, RES_NONE},
        '{REQ_SLEEP, 4'd15, 4'd1,  1'b0, RES_NONE},
        '{REQ_RUN,   4'd15, 4'd1,  1'b0, RES_NONE}
    };

    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 280;
    localparam int SETTLE_CYCLES = 2 * TASK_SLOTS_DEF + 20;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;
    logic [1:0]       s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [23:0]      m_tdata;
    logic             cfg_wen;
    logic [FTD_W-1:0] cfg_wdata;

    // scheduler state as seen by the predictor
    slot_state_t      slot_state [TASK_SLOTS_DEF];
    logic [3:0]       run_order [TASK_SLOTS_DEF];
    int               running_cnt;
    int               cur_pos;
    logic [FTD_W-1:0] desc_base;

    sched_result_t    pending_results [$];
    int               mismatches;
    int               burst_left;
    bit               hold_off_due;

    round_robin_task_scheduler i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #2000000;
        $display("round_robin_task_scheduler_tb NOT OK");
        $finish;
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h, want %0h", what, got, want);
        mismatches++;
    endtask

    function automatic sched_result_t slot_result(logic sw, logic [3:0] s);
        sched_result_t r;
        r.status     = ST_OK;
        r.switch_now = sw;
        r.slot       = s;
        r.selector   = (16'(desc_base) + 16'(s)) << 3;
        return r;
    endfunction

    // Apply one request to the predicted state and return the result it gives.
    function automatic sched_result_t schedule(req_t req, logic [3:0] id);
        sched_result_t r;
        int            idx;
        bit            was_cur;
        r = RES_NONE;
        case (req)
            REQ_ALLOC:
            begin
                r = RES_FULL;
                for (idx = 0; idx < TASK_SLOTS_DEF; idx++)
                begin
                    if (slot_state[idx] == SLOT_FREE)
                    begin
                        slot_state[idx] = SLOT_ALLOC;
                        r = slot_result(1'b0, 4'(idx));
                        break;
                    end
                end
            end
            REQ_RUN:
            begin
                if (slot_state[id] == SLOT_ALLOC && running_cnt < TASK_SLOTS_DEF)
                begin
                    slot_state[id] = SLOT_RUN;
                    run_order[running_cnt] = id;
                    running_cnt++;
                end
                else
                begin
                    r = RES_IGNORED;
                end
            end
            REQ_TICK:
            begin
                if (running_cnt >= 2)
                begin
                    cur_pos++;
                    if (cur_pos >= running_cnt)
                        cur_pos = 0;
                    r = slot_result(1'b1, run_order[cur_pos]);
                end
            end
            default:
            begin
                if (slot_state[id] != SLOT_RUN || running_cnt == 0)
                begin
                    r = RES_IGNORED;
                end
                else
                begin
                    was_cur = (cur_pos < running_cnt) && (run_order[cur_pos] == id);
                    idx = 0;
                    while (idx < running_cnt && run_order[idx] != id)
                        idx++;
                    slot_state[id] = SLOT_ALLOC;
                    if (idx >= running_cnt)
                    begin
                        // running mark without a list entry: drop the mark only
                        r = RES_IGNORED;
                    end
                    else
                    begin
                        running_cnt--;
                        if (idx < cur_pos)
                            cur_pos--;
                        while (idx < running_cnt)
                        begin
                            run_order[idx] = run_order[idx + 1];
                            idx++;
                        end
                        if (was_cur || cur_pos >= running_cnt)
                            cur_pos = 0;
                        if (running_cnt > 0)
                            r = slot_result(1'b1, run_order[cur_pos]);
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Offer one request, hold it until the transfer, then queue its result.
    task automatic send(req_t req, logic [3:0] id, logic typed, sched_result_t want);
        sched_result_t r;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {4'b0000, id};
        do
            @(posedge clk);
        while (!s_tready);
        r = schedule(req, id);
        pending_results.push_back(typed ? want : r);
    endtask

    // Keep requests back-to-back within a burst; idle a random gap between bursts.
    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        sched_result_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report("result with nothing pending", 32'(m_tdata), 32'd0);
            end
            else
            begin
                w = pending_results.pop_front();
                if (m_tdata[1:0] != w.status)
                    report("status", 32'(m_tdata[1:0]), 32'(w.status));
                if (m_tdata[2] != w.switch_now)
                    report("switch_now", 32'(m_tdata[2]), 32'(w.switch_now));
                if (m_tdata[6:3] != w.slot)
                    report("result_task", 32'(m_tdata[6:3]), 32'(w.slot));
                if (m_tdata[22:7] != w.selector)
                    report("selector", 32'(m_tdata[22:7]), 32'(w.selector));
            end
        end
    end

    // receiver: stretches of random stall density, plus one long hold-off on request
    initial
    begin : receiver
        int len;
        int pct;
        m_tready <= 1'b0;
        forever
        begin
            if (hold_off_due)
            begin
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off_due = 1'b0;
            end
            else
            begin
                len = $urandom_range(1, 40);
                case ($urandom_range(0, 3))
                    0:       pct = 100;
                    1:       pct = 75;
                    2:       pct = 40;
                    default: pct = 10;
                endcase
                repeat (len)
                begin
                    m_tready <= ($urandom_range(0, 99) < pct);
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin : sender
        req_t       req;
        logic [3:0] id;
        logic [3:0] cand [$];
        int         pick;
        int         r;
        int         n;
        int         ph;
        int         s;
        logic [FTD_W-1:0] phase_base;

        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= '0;
        cfg_wen      <= 1'b0;
        cfg_wdata    <= '0;
        rst_n         = 1'b0;
        mismatches    = 0;
        burst_left    = 0;
        hold_off_due  = 1'b0;

        for (s = 0; s < TASK_SLOTS_DEF; s++)
        begin
            slot_state[s] = SLOT_FREE;
            run_order[s]  = 4'd0;
        end
        slot_state[0] = SLOT_RUN;
        running_cnt   = 1;
        cur_pos       = 0;
        desc_base     = FTD_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < N_ROWS; r++)
        begin
            for (n = 0; n < DIRECTED[r].reps; n++)
            begin
                send(DIRECTED[r].req, DIRECTED[r].id, DIRECTED[r].typed, DIRECTED[r].want);
                pace();
            end
        end
        drain();

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       phase_base = '0;
                1:       phase_base = '1;
                4:       phase_base = '1;
                default: phase_base = FTD_W'($urandom_range(0, (1 << FTD_W) - 1));
            endcase
            // block is idle here: write the descriptor base
            cfg_wdata <= phase_base;
            cfg_wen   <= 1'b1;
            @(posedge clk);
            cfg_wen   <= 1'b0;
            desc_base  = phase_base;

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 0 && n == 60)
                    hold_off_due = 1'b1;
                pick = $urandom_range(0, 99);
                id   = 4'($urandom_range(0, 15));
                cand.delete();
                if (pick < 12)
                begin
                    req = REQ_ALLOC;
                end
                else if (pick < 42)
                begin
                    req = REQ_RUN;
                    for (s = 0; s < TASK_SLOTS_DEF; s++)
                        if (slot_state[s] == SLOT_ALLOC)
                            cand.push_back(4'(s));
                end
                else if (pick < 70)
                begin
                    req = REQ_TICK;
                end
                else
                begin
                    req = REQ_SLEEP;
                    for (s = 0; s < running_cnt; s++)
                        cand.push_back(run_order[s]);
                end
                // mostly target a slot in the right state, sometimes any slot
                if (cand.size() > 0 && $urandom_range(0, 9) < 8)
                    id = cand[$urandom_range(0, cand.size() - 1)];
                send(req, id, 1'b0, RES_NONE);
                if ($urandom_range(0, 149) == 0)
                    drain();
                else
                    pace();
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("round_robin_task_scheduler_tb OK");
        else
            $display("round_robin_task_scheduler_tb NOT OK");
        $finish;
    end

endmodule
